>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl; empty bodies when synthesising
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked property, held off while reset is asserted
`define PRCP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("prcp assertion failed");
// checked property, active during reset as well
`define PRCP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("prcp assertion failed");
`else
`define PRCP_ASSERT(label, clk, rst_n, prop)
`define PRCP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> design/prcp_pkg.sv
// ----------------------------------------------------------------------------
// prcp_pkg
// shared constants, types and helper functions of the planar predictor
// ----------------------------------------------------------------------------
package prcp_pkg;

  // sizing
  localparam int MAX_WIDTH     = 2048;
  localparam int CONTEXT_COUNT = 16;
  localparam int MAX_HEIGHT    = 4096;

  localparam int ADDR_W   = $clog2(MAX_WIDTH);
  localparam int CNT_W    = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W    = 12;
  localparam int HGT_W    = 13;
  localparam int SAMPLE_W = 16;
  localparam int EXT_W    = 18;
  localparam int MAPPED_W = 19;
  localparam int CTX_W    = 4;
  localparam int BLEN_W   = 5;
  localparam int BW_W     = 12;
  localparam int BH_W     = 13;
  localparam int CFG_W    = 13;
  localparam int IDX_W    = 1;

  localparam logic [BW_W-1:0] BW_RESET = BW_W'(256);
  localparam logic [BH_W-1:0] BH_RESET = BH_W'(256);

  // context values
  localparam logic [CTX_W-1:0]  CTX_TOP   = CTX_W'(CONTEXT_COUNT - 1);
  localparam logic [BLEN_W-1:0] CTX_CLAMP = BLEN_W'(CONTEXT_COUNT - 2);
  localparam logic [CTX_W-1:0]  CTX_NONE  = '0;

  // register indexes
  localparam logic [IDX_W-1:0] REG_BAND_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_BAND_HEIGHT = 1'b1;

  // code kinds
  localparam logic KIND_RAW   = 1'b0;
  localparam logic KIND_RESID = 1'b1;

  // position of one item in the band
  typedef struct packed {
    logic              first;
    logic              row0;
    logic              col0;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } pos_t;

  // one result item
  typedef struct packed {
    logic                code_kind;
    logic [MAPPED_W-1:0] mapped;
    logic [CTX_W-1:0]    ctx;
    logic                last;
  } res_t;

  // 0,-1,1,-2 -> 0,1,2,3
  function automatic logic [MAPPED_W-1:0] zigzag(input logic signed [EXT_W-1:0] v);
    zigzag = {v ^ {EXT_W{v[EXT_W-1]}}, v[EXT_W-1]};
  endfunction

  // index of the highest set bit plus one, zero for zero
  function automatic logic [BLEN_W-1:0] bit_length(input logic [EXT_W-1:0] v);
    logic [BLEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < EXT_W; i++) begin
      if (v[i]) begin
        n = BLEN_W'(i + 1);
      end
    end
    bit_length = n;
  endfunction

endpackage

>>> design/prcp_line_store.sv
// ----------------------------------------------------------------------------
// prcp_line_store
// previous-row memory with registered read and same-address forwarding
// ----------------------------------------------------------------------------
module prcp_line_store (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               rd_en,
  input  logic [prcp_pkg::ADDR_W-1:0]        rd_addr,
  input  logic                               wr_en,
  input  logic [prcp_pkg::ADDR_W-1:0]        wr_addr,
  input  logic signed [prcp_pkg::SAMPLE_W-1:0] wr_data,
  output logic signed [prcp_pkg::SAMPLE_W-1:0] rd_above
);

  logic [prcp_pkg::SAMPLE_W-1:0] mem [prcp_pkg::MAX_WIDTH];
  logic [prcp_pkg::SAMPLE_W-1:0] rdata_r;
  logic [prcp_pkg::SAMPLE_W-1:0] fwd_data_r;
  logic                          fwd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r    <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // a read that meets a write to the same entry takes the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_above = fwd_hit_r ? $signed(fwd_data_r) : $signed(rdata_r);

endmodule

>>> design/prcp_position.sv
// ----------------------------------------------------------------------------
// prcp_position
// band size registers and the raster position of the next item
// ----------------------------------------------------------------------------
module prcp_position (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [prcp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [prcp_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         accept,
  output prcp_pkg::pos_t               pos
);

  logic [prcp_pkg::BW_W-1:0]   band_width_r;
  logic [prcp_pkg::BH_W-1:0]   band_height_r;
  logic [prcp_pkg::ADDR_W-1:0] col_r, col_nxt;
  logic [prcp_pkg::ROW_W-1:0]  row_r, row_nxt;

  logic [prcp_pkg::CNT_W-1:0]  eff_w;
  logic [prcp_pkg::HGT_W-1:0]  eff_h;
  logic [prcp_pkg::CNT_W-1:0]  col_c;
  logic                        col_end;
  logic                        row_end;

  always_comb begin
    priority if (band_width_r == '0) begin
      eff_w = prcp_pkg::CNT_W'(1);
    end else if (int'(band_width_r) > prcp_pkg::MAX_WIDTH) begin
      eff_w = prcp_pkg::CNT_W'(prcp_pkg::MAX_WIDTH);
    end else begin
      eff_w = prcp_pkg::CNT_W'(band_width_r);
    end

    priority if (band_height_r == '0) begin
      eff_h = prcp_pkg::HGT_W'(1);
    end else if (int'(band_height_r) > prcp_pkg::MAX_HEIGHT) begin
      eff_h = prcp_pkg::HGT_W'(prcp_pkg::MAX_HEIGHT);
    end else begin
      eff_h = band_height_r;
    end
  end

  always_comb begin
    col_c = prcp_pkg::CNT_W'(col_r);
    if (col_c >= eff_w) begin
      col_c = eff_w - prcp_pkg::CNT_W'(1);
    end
    col_end = (col_c == eff_w - prcp_pkg::CNT_W'(1));
    row_end = (prcp_pkg::HGT_W'(row_r) + prcp_pkg::HGT_W'(1) >= eff_h);

    pos.addr  = prcp_pkg::ADDR_W'(col_c);
    pos.row0  = (row_r == '0);
    pos.col0  = (col_c == '0);
    pos.first = pos.row0 && pos.col0;
    pos.last  = row_end && col_end;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + prcp_pkg::ROW_W'(1);
      end else begin
        col_nxt = prcp_pkg::ADDR_W'(col_c + prcp_pkg::CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_width_r  <= prcp_pkg::BW_RESET;
      band_height_r <= prcp_pkg::BH_RESET;
      col_r         <= '0;
      row_r         <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          prcp_pkg::REG_BAND_WIDTH:  band_width_r  <= cfg_wdata[prcp_pkg::BW_W-1:0];
          prcp_pkg::REG_BAND_HEIGHT: band_height_r <= cfg_wdata[prcp_pkg::BH_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> design/prcp_predict.sv
// ----------------------------------------------------------------------------
// prcp_predict
// planar prediction, zigzag mapping and gradient context for one item
// ----------------------------------------------------------------------------
module prcp_predict (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  prcp_pkg::pos_t                       pos,
  input  logic signed [prcp_pkg::SAMPLE_W-1:0] cur,
  input  logic signed [prcp_pkg::SAMPLE_W-1:0] above,
  output prcp_pkg::res_t                       res
);

  localparam int SW = prcp_pkg::SAMPLE_W;
  localparam int XW = prcp_pkg::EXT_W;

  logic signed [SW-1:0] left_r;
  logic signed [SW-1:0] ul_r;

  logic signed [XW-1:0] cur_x, left_x, above_x, ul_x;
  logic signed [XW-1:0] pred, resid, g_l, g_a;
  logic [XW-1:0]        abs_l, abs_a, grad;
  logic [prcp_pkg::BLEN_W-1:0] blen;

  always_comb begin
    cur_x   = {{(XW-SW){cur[SW-1]}}, cur};
    left_x  = {{(XW-SW){left_r[SW-1]}}, left_r};
    above_x = {{(XW-SW){above[SW-1]}}, above};
    ul_x    = {{(XW-SW){ul_r[SW-1]}}, ul_r};

    priority if (pos.first) begin
      pred = '0;
    end else if (pos.row0) begin
      pred = left_x;
    end else if (pos.col0) begin
      pred = above_x;
    end else begin
      pred = left_x + above_x - ul_x;
    end
    resid = cur_x - pred;

    g_l   = left_x - ul_x;
    g_a   = above_x - ul_x;
    abs_l = g_l[XW-1] ? XW'(-g_l) : XW'(g_l);
    abs_a = g_a[XW-1] ? XW'(-g_a) : XW'(g_a);
    grad  = abs_l + abs_a;
    blen  = prcp_pkg::bit_length(grad);
    if (blen > prcp_pkg::CTX_CLAMP) begin
      blen = prcp_pkg::CTX_CLAMP;
    end

    res.mapped = prcp_pkg::zigzag(resid);
    res.last   = pos.last;
    priority if (pos.first) begin
      res.code_kind = prcp_pkg::KIND_RAW;
      res.ctx       = prcp_pkg::CTX_NONE;
    end else if (pos.row0 || pos.col0) begin
      res.code_kind = prcp_pkg::KIND_RESID;
      res.ctx       = prcp_pkg::CTX_TOP;
    end else begin
      res.code_kind = prcp_pkg::KIND_RESID;
      res.ctx       = blen[prcp_pkg::CTX_W-1:0];
    end
  end

  // neighbours move along as each item leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      ul_r   <= '0;
    end else if (adv) begin
      left_r <= cur;
      ul_r   <= above;
    end
  end

endmodule

>>> design/planar_residual_context_predictor.sv
// ----------------------------------------------------------------------------
// planar_residual_context_predictor
// residual and coding context for wavelet band coefficients in raster order
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------
//   in_      | input     | in_valid/in_ready   | sample
//   out_     | output    | out_valid/out_ready | code_kind, mapped_residual,
//            |           |                     | context_res, last_of_band
//   cfg_     | input     | cfg_we              | cfg_index, cfg_wdata
//
// one item per clock sustained while out_ready holds high; an item accepted
// is registered into the prediction stage along with its line store read,
// then its prediction is registered into the output register shown at out_
// the single-port-per-direction line store sets the pace: one read and one
// write of the previous row per cycle
// synchronous active-low reset; no clearing pass, row 0 fills the line store
// before any later row reads it
// a stalled output holds its item while the prediction stage can still fill
//
module planar_residual_context_predictor (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [prcp_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_code_kind,
  output logic [prcp_pkg::MAPPED_W-1:0]         out_mapped_residual,
  output logic [prcp_pkg::CTX_W-1:0]            out_context_res,
  output logic                                  out_last_of_band,
  input  logic                                  cfg_we,
  input  logic [prcp_pkg::IDX_W-1:0]            cfg_index,
  input  logic [prcp_pkg::CFG_W-1:0]            cfg_wdata
);

`include "assert_macros.svh"

  // handshake
  logic accept;
  logic s1_adv;

  // position of the item being accepted
  prcp_pkg::pos_t pos;

  // prediction stage: item waiting on its line store read
  logic                                 s1_v_r, s1_v_nxt;
  prcp_pkg::pos_t                       s1_pos_r;
  logic signed [prcp_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic signed [prcp_pkg::SAMPLE_W-1:0] above;
  prcp_pkg::res_t                       res;

  // output register
  logic           out_v_r, out_v_nxt;
  prcp_pkg::res_t out_r;

  // stage moves when the output register is free or being drained
  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign accept   = in_valid && in_ready;

  prcp_position u_position (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .pos       (pos)
  );

  // read the entry above on accept, write the item back as it leaves
  prcp_line_store u_line_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (pos.addr),
    .wr_en    (s1_adv),
    .wr_addr  (s1_pos_r.addr),
    .wr_data  (s1_sample_r),
    .rd_above (above)
  );

  prcp_predict u_predict (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_adv),
    .pos   (s1_pos_r),
    .cur   (s1_sample_r),
    .above (above),
    .res   (res)
  );

  always_comb begin
    priority if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end

    priority if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r    <= pos;
      s1_sample_r <= in_sample;
    end
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_v_r;
  assign out_code_kind       = out_r.code_kind;
  assign out_mapped_residual = out_r.mapped;
  assign out_context_res     = out_r.ctx;
  assign out_last_of_band    = out_r.last;

  // checks
  `PRCP_ASSERT(a_accept_fills_stage, clk, rst_n, accept |=> s1_v_r)
  `PRCP_ASSERT(a_adv_fills_output, clk, rst_n, s1_adv |=> out_valid)
  `PRCP_ASSERT(a_cfg_restarts_band, clk, rst_n, cfg_we |=> pos.first)
  `PRCP_ASSERT(a_raw_has_no_context, clk, rst_n,
    (out_valid && (out_code_kind == prcp_pkg::KIND_RAW)) |-> (out_context_res == prcp_pkg::CTX_NONE))

endmodule
